// File: hdl/csp_pkg.sv
// Shared constants for the circle/segment push-out pipeline.
// No dependencies; used by the top level (parameter defaults, T_BITS) and the testbench.
package csp_pkg;

    // Default coordinate word width and fraction bits (Q16.16)
    localparam int COORD_WIDTH = 32;
    localparam int FRAC_BITS   = 16;

    // Fraction bits of the projection parameter t
    localparam int T_BITS      = 32;

endpackage

// File: hdl/csp_div_pipe.sv
// Pipelined restoring divider, one quotient bit per register stage.
// Carries an opaque sideband vector alongside each transaction. No package use.
module csp_div_pipe #(
    parameter int D_W    = 31,
    parameter int STEPS  = 31,
    parameter int SIDE_W = 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              ce,
    input  logic              in_valid,
    input  logic [D_W-1:0]    rem_in,    // partial remainder, must be below div_in
    input  logic [STEPS-1:0]  qn_in,     // dividend bits still to shift in, MSB first
    input  logic [D_W-1:0]    div_in,
    input  logic [SIDE_W-1:0] side_in,
    output logic              out_valid,
    output logic [STEPS-1:0]  q_out,
    output logic [SIDE_W-1:0] side_out
);

    logic [STEPS-1:0]  v_reg;
    logic [D_W-1:0]    rem_reg  [STEPS];
    logic [D_W-1:0]    rem_next [STEPS];
    logic [STEPS-1:0]  qn_reg   [STEPS];
    logic [STEPS-1:0]  qn_next  [STEPS];
    logic [D_W-1:0]    dv_reg   [STEPS];
    logic [SIDE_W-1:0] sd_reg   [STEPS];

    logic [D_W-1:0]    rem_src  [STEPS];
    logic [STEPS-1:0]  qn_src   [STEPS];
    logic [D_W-1:0]    dv_src   [STEPS];
    logic [SIDE_W-1:0] sd_src   [STEPS];
    logic [D_W:0]      cand     [STEPS];
    logic [D_W:0]      diff     [STEPS];
    logic              qbit     [STEPS];

    // Per-stage trial subtract; quotient bits shift in where dividend bits leave
    always_comb
    begin
        rem_src[0] = rem_in;
        qn_src[0]  = qn_in;
        dv_src[0]  = div_in;
        sd_src[0]  = side_in;
        for (int i = 1; i < STEPS; i++)
        begin
            rem_src[i] = rem_reg[i-1];
            qn_src[i]  = qn_reg[i-1];
            dv_src[i]  = dv_reg[i-1];
            sd_src[i]  = sd_reg[i-1];
        end
        for (int i = 0; i < STEPS; i++)
        begin
            cand[i]     = {rem_src[i], qn_src[i][STEPS-1]};
            diff[i]     = cand[i] - {1'b0, dv_src[i]};
            qbit[i]     = (cand[i] >= {1'b0, dv_src[i]});
            rem_next[i] = qbit[i] ? diff[i][D_W-1:0] : cand[i][D_W-1:0];
            qn_next[i]  = {qn_src[i][STEPS-2:0], qbit[i]};
        end
    end

    // Valid shift line
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (ce)
        begin
            v_reg <= {v_reg[STEPS-2:0], in_valid};
        end
    end

    // Payload stages
    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            for (int i = 0; i < STEPS; i++)
            begin
                rem_reg[i] <= rem_next[i];
                qn_reg[i]  <= qn_next[i];
                dv_reg[i]  <= dv_src[i];
                sd_reg[i]  <= sd_src[i];
            end
        end
    end

    assign out_valid = v_reg[STEPS-1];
    assign q_out     = qn_reg[STEPS-1];
    assign side_out  = sd_reg[STEPS-1];

endmodule

// File: hdl/csp_isqrt_pipe.sv
// Pipelined integer square root, one root bit (two radicand bits) per stage.
// Carries an opaque sideband vector alongside each transaction. No package use.
module csp_isqrt_pipe #(
    parameter int N      = 31,
    parameter int SIDE_W = 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              ce,
    input  logic              in_valid,
    input  logic [2*N-1:0]    rad_in,
    input  logic [SIDE_W-1:0] side_in,
    output logic              out_valid,
    output logic [N-1:0]      root_out,  // floor(sqrt(rad_in))
    output logic [SIDE_W-1:0] side_out
);

    logic [N-1:0]      v_reg;
    logic [N:0]        rem_reg   [N];
    logic [N:0]        rem_next  [N];
    logic [N-1:0]      root_reg  [N];
    logic [N-1:0]      root_next [N];
    logic [2*N-1:0]    rad_reg   [N];
    logic [SIDE_W-1:0] sd_reg    [N];

    logic [N:0]        rem_src   [N];
    logic [N-1:0]      root_src  [N];
    logic [2*N-1:0]    rad_src   [N];
    logic [SIDE_W-1:0] sd_src    [N];
    logic [N+2:0]      cand      [N];
    logic [N+2:0]      trial     [N];
    logic [N+2:0]      diff      [N];
    logic              rbit      [N];

    // Digit-by-digit root: try (4*root + 1) against the remainder
    always_comb
    begin
        rem_src[0]  = '0;
        root_src[0] = '0;
        rad_src[0]  = rad_in;
        sd_src[0]   = side_in;
        for (int i = 1; i < N; i++)
        begin
            rem_src[i]  = rem_reg[i-1];
            root_src[i] = root_reg[i-1];
            rad_src[i]  = rad_reg[i-1];
            sd_src[i]   = sd_reg[i-1];
        end
        for (int i = 0; i < N; i++)
        begin
            cand[i]      = {rem_src[i], rad_src[i][2*N-1:2*N-2]};
            trial[i]     = {1'b0, root_src[i], 2'b01};
            diff[i]      = cand[i] - trial[i];
            rbit[i]      = (cand[i] >= trial[i]);
            rem_next[i]  = rbit[i] ? diff[i][N:0] : cand[i][N:0];
            root_next[i] = {root_src[i][N-2:0], rbit[i]};
        end
    end

    // Valid shift line
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (ce)
        begin
            v_reg <= {v_reg[N-2:0], in_valid};
        end
    end

    // Payload stages
    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            for (int i = 0; i < N; i++)
            begin
                rem_reg[i]  <= rem_next[i];
                root_reg[i] <= root_next[i];
                rad_reg[i]  <= {rad_src[i][2*N-3:0], 2'b00};
                sd_reg[i]   <= sd_src[i];
            end
        end
    end

    assign out_valid = v_reg[N-1];
    assign root_out  = root_reg[N-1];
    assign side_out  = sd_reg[N-1];

endmodule

// File: hdl/circle_segment_pushout.sv
// Top level of the circle versus line-segment push-out pipeline.
// Depends on csp_pkg, csp_div_pipe and csp_isqrt_pipe.
//
// Streaming circle/segment collision test. Each input transaction carries a
// circle (centre, radius) and a segment (two XY endpoints) in signed fixed
// point; each produces exactly one output transaction with a hit flag and the
// push-out vector (zero on a miss). The pipeline accepts one transaction per
// clock while not stalled and is built from three front stages, a 32-stage
// divider for the projection parameter, four stages for closest point and
// squared distance, a COORD_WIDTH-1 stage square root, two overlap stages,
// a COORD_WIDTH-1 stage divider for the push components and the output
// register. Back-pressure on m_tready freezes the whole pipeline; s_tready is
// low only while a result waits in the output register and m_tready is low.
module circle_segment_pushout #(
    parameter int COORD_WIDTH = csp_pkg::COORD_WIDTH,
    parameter int FRAC_BITS   = csp_pkg::FRAC_BITS
) (
    input  logic clk,
    input  logic rst_n,
    // slave side: center_x, center_y, circle_radius, start_x, start_y, end_x, end_y
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    input  logic [((7*COORD_WIDTH-1+7)/8)*8-1:0]   s_tdata,
    // master side tdata: push_x, push_y
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    output logic [((2*COORD_WIDTH+7)/8)*8-1:0]     m_tdata,
    // master side tuser: hit
    output logic [0:0]                             m_tuser
);

    localparam int W      = COORD_WIDTH;
    localparam int AW     = W + 1;           // coordinate differences
    localparam int LW     = 2 * AW;          // squares and dot products
    localparam int RW     = W - 1;           // radius, root, distance
    localparam int TB     = csp_pkg::T_BITS;
    localparam int TW     = TB + 1;
    localparam int OUT_TW = ((2 * W + 7) / 8) * 8;

    localparam logic [LW-1:0] LEN2_MIN =
        LW'(((64'd1 << (2 * FRAC_BITS)) + 64'd50000000) / 64'd100000000);
    localparam int DMIN_RAW = ((1 << FRAC_BITS) + 500) / 1000;
    localparam logic [RW-1:0] DIST_MIN = RW'((DMIN_RAW == 0) ? 1 : DMIN_RAW);

    localparam int SIDE_T = 7 * W + 6;
    localparam int SIDE_S = 3 + 3 * RW;

    logic ce;
    logic m_tvalid_reg;

    assign ce       = !m_tvalid_reg || m_tready;
    assign s_tready = ce;

    // Input fields
    logic signed [W-1:0] in_cx, in_cy, in_sx, in_sy, in_ex, in_ey;
    logic [RW-1:0]       in_r;

    assign in_cx = $signed(s_tdata[W-1:0]);
    assign in_cy = $signed(s_tdata[2*W-1:W]);
    assign in_r  = s_tdata[3*W-2:2*W];
    assign in_sx = $signed(s_tdata[4*W-2:3*W-1]);
    assign in_sy = $signed(s_tdata[5*W-2:4*W-1]);
    assign in_ex = $signed(s_tdata[6*W-2:5*W-1]);
    assign in_ey = $signed(s_tdata[7*W-2:6*W-1]);

    // ---------------- stage 1: differences ----------------
    logic                 v1_reg;
    logic signed [W-1:0]  ax1_reg, ay1_reg, px1_reg, py1_reg;
    logic [RW-1:0]        r1_reg;
    logic signed [AW-1:0] abx1_reg, aby1_reg, pax1_reg, pay1_reg;

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            ax1_reg  <= in_sx;
            ay1_reg  <= in_sy;
            px1_reg  <= in_cx;
            py1_reg  <= in_cy;
            r1_reg   <= in_r;
            abx1_reg <= AW'(in_ex) - AW'(in_sx);
            aby1_reg <= AW'(in_ey) - AW'(in_sy);
            pax1_reg <= AW'(in_cx) - AW'(in_sx);
            pay1_reg <= AW'(in_cy) - AW'(in_sy);
        end
    end

    // ---------------- stage 2: products, magnitudes ----------------
    logic                 v2_reg;
    logic signed [LW-1:0] sqx_p, sqy_p, dpx_p, dpy_p;
    logic signed [LW-1:0] sqx2_reg, sqy2_reg, dpx2_reg, dpy2_reg;
    logic signed [W-1:0]  ax2_reg, ay2_reg, px2_reg, py2_reg;
    logic [RW-1:0]        r2_reg;
    logic                 sx2_reg, sy2_reg;
    logic [AW-1:0]        magx2_reg, magy2_reg;

    assign sqx_p = abx1_reg * abx1_reg;
    assign sqy_p = aby1_reg * aby1_reg;
    assign dpx_p = pax1_reg * abx1_reg;
    assign dpy_p = pay1_reg * aby1_reg;

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            sqx2_reg  <= sqx_p;
            sqy2_reg  <= sqy_p;
            dpx2_reg  <= dpx_p;
            dpy2_reg  <= dpy_p;
            ax2_reg   <= ax1_reg;
            ay2_reg   <= ay1_reg;
            px2_reg   <= px1_reg;
            py2_reg   <= py1_reg;
            r2_reg    <= r1_reg;
            sx2_reg   <= abx1_reg[AW-1];
            sy2_reg   <= aby1_reg[AW-1];
            magx2_reg <= abx1_reg[AW-1] ? $unsigned(-abx1_reg) : $unsigned(abx1_reg);
            magy2_reg <= aby1_reg[AW-1] ? $unsigned(-aby1_reg) : $unsigned(aby1_reg);
        end
    end

    // ---------------- stage 3: len2, dot, t classification ----------------
    logic [LW-1:0]        len2_n;
    logic signed [LW-1:0] dot_n;
    logic                 v3_reg;
    logic [LW-1:0]        len23_reg, dot3_reg;
    logic                 degen3_reg, tzero3_reg, tone3_reg;
    logic                 sx3_reg, sy3_reg;
    logic [AW-1:0]        magx3_reg, magy3_reg;
    logic signed [W-1:0]  ax3_reg, ay3_reg, px3_reg, py3_reg;
    logic [RW-1:0]        r3_reg;

    assign len2_n = $unsigned(sqx2_reg) + $unsigned(sqy2_reg);
    assign dot_n  = dpx2_reg + dpy2_reg;

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            len23_reg  <= len2_n;
            dot3_reg   <= $unsigned(dot_n);
            degen3_reg <= (len2_n < LEN2_MIN) || (len2_n == '0);
            tzero3_reg <= dot_n[LW-1] || (dot_n == '0);
            tone3_reg  <= !dot_n[LW-1] && ($unsigned(dot_n) >= len2_n);
            sx3_reg    <= sx2_reg;
            sy3_reg    <= sy2_reg;
            magx3_reg  <= magx2_reg;
            magy3_reg  <= magy2_reg;
            ax3_reg    <= ax2_reg;
            ay3_reg    <= ay2_reg;
            px3_reg    <= px2_reg;
            py3_reg    <= py2_reg;
            r3_reg     <= r2_reg;
        end
    end

    // ---------------- projection divider: t = dot * 2^TB / len2 ----------------
    logic [SIDE_T-1:0]    tside_in, tside_out;
    logic                 tdiv_valid;
    logic [TB-1:0]        tq;
    logic                 degen_t, tzero_t, tone_t, sx_t, sy_t;
    logic [AW-1:0]        magx_t, magy_t;
    logic signed [W-1:0]  ax_t, ay_t, px_t, py_t;
    logic [RW-1:0]        r_t;

    assign tside_in = {degen3_reg, tzero3_reg, tone3_reg, sx3_reg, sy3_reg,
                       magx3_reg, magy3_reg, ax3_reg, ay3_reg, px3_reg, py3_reg, r3_reg};
    assign {degen_t, tzero_t, tone_t, sx_t, sy_t,
            magx_t, magy_t, ax_t, ay_t, px_t, py_t, r_t} = tside_out;

    csp_div_pipe #(
        .D_W    (LW),
        .STEPS  (TB),
        .SIDE_W (SIDE_T)
    ) u_tdiv (
        .clk       (clk),
        .rst_n     (rst_n),
        .ce        (ce),
        .in_valid  (v3_reg),
        .rem_in    (dot3_reg),
        .qn_in     ('0),
        .div_in    (len23_reg),
        .side_in   (tside_in),
        .out_valid (tdiv_valid),
        .q_out     (tq),
        .side_out  (tside_out)
    );

    // ---------------- stage 4: offset along the segment ----------------
    logic [TW-1:0]        t_sel;
    logic [TW+AW-1:0]     offx_p, offy_p;
    logic                 v4_reg;
    logic [AW-1:0]        mx4_reg, my4_reg;
    logic                 sx4_reg, sy4_reg, degen4_reg;
    logic signed [W-1:0]  ax4_reg, ay4_reg, px4_reg, py4_reg;
    logic [RW-1:0]        r4_reg;

    always_comb
    begin
        priority if (tone_t)
        begin
            t_sel = TW'(1) << TB;
        end
        else if (tzero_t)
        begin
            t_sel = '0;
        end
        else
        begin
            t_sel = {1'b0, tq};
        end
    end

    assign offx_p = t_sel * magx_t;
    assign offy_p = t_sel * magy_t;

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            mx4_reg    <= offx_p[TB+AW-1:TB];
            my4_reg    <= offy_p[TB+AW-1:TB];
            sx4_reg    <= sx_t;
            sy4_reg    <= sy_t;
            degen4_reg <= degen_t;
            ax4_reg    <= ax_t;
            ay4_reg    <= ay_t;
            px4_reg    <= px_t;
            py4_reg    <= py_t;
            r4_reg     <= r_t;
        end
    end

    // ---------------- stage 5: closest point and centre offset ----------------
    logic signed [W+1:0]  cx_w, cy_w, dx_w, dy_w;
    logic                 v5_reg;
    logic signed [AW-1:0] dx5_reg, dy5_reg;
    logic                 degen5_reg;
    logic [RW-1:0]        r5_reg;

    assign cx_w = sx4_reg ? ((W+2)'(ax4_reg) - $signed({1'b0, mx4_reg}))
                          : ((W+2)'(ax4_reg) + $signed({1'b0, mx4_reg}));
    assign cy_w = sy4_reg ? ((W+2)'(ay4_reg) - $signed({1'b0, my4_reg}))
                          : ((W+2)'(ay4_reg) + $signed({1'b0, my4_reg}));
    assign dx_w = (W+2)'(px4_reg) - cx_w;
    assign dy_w = (W+2)'(py4_reg) - cy_w;

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            dx5_reg    <= dx_w[AW-1:0];
            dy5_reg    <= dy_w[AW-1:0];
            degen5_reg <= degen4_reg;
            r5_reg     <= r4_reg;
        end
    end

    // ---------------- stage 6: squares ----------------
    logic signed [LW-1:0] sdx_p, sdy_p;
    logic [2*RW-1:0]      rr_p;
    logic [AW-1:0]        absdx, absdy;
    logic                 v6_reg;
    logic signed [LW-1:0] sdx6_reg, sdy6_reg;
    logic [2*RW-1:0]      rr6_reg;
    logic [RW-1:0]        magdx6_reg, magdy6_reg, r6_reg;
    logic                 sdx6s_reg, sdy6s_reg, degen6_reg;

    assign sdx_p = dx5_reg * dx5_reg;
    assign sdy_p = dy5_reg * dy5_reg;
    assign rr_p  = r5_reg * r5_reg;
    assign absdx = dx5_reg[AW-1] ? $unsigned(-dx5_reg) : $unsigned(dx5_reg);
    assign absdy = dy5_reg[AW-1] ? $unsigned(-dy5_reg) : $unsigned(dy5_reg);

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            sdx6_reg   <= sdx_p;
            sdy6_reg   <= sdy_p;
            rr6_reg    <= rr_p;
            magdx6_reg <= absdx[RW-1:0];   // fits whenever the circle hits
            magdy6_reg <= absdy[RW-1:0];
            sdx6s_reg  <= dx5_reg[AW-1];
            sdy6s_reg  <= dy5_reg[AW-1];
            degen6_reg <= degen5_reg;
            r6_reg     <= r5_reg;
        end
    end

    // ---------------- stage 7: squared distance and hit test ----------------
    logic [LW-1:0]        dist2_n;
    logic                 v7_reg;
    logic [2*RW-1:0]      rad7_reg;
    logic                 hit7_reg, sdx7_reg, sdy7_reg;
    logic [RW-1:0]        magdx7_reg, magdy7_reg, r7_reg;

    assign dist2_n = $unsigned(sdx6_reg) + $unsigned(sdy6_reg);

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            rad7_reg   <= dist2_n[2*RW-1:0];
            hit7_reg   <= !degen6_reg && (dist2_n < LW'(rr6_reg));
            sdx7_reg   <= sdx6s_reg;
            sdy7_reg   <= sdy6s_reg;
            magdx7_reg <= magdx6_reg;
            magdy7_reg <= magdy6_reg;
            r7_reg     <= r6_reg;
        end
    end

    // ---------------- square root of dist2 ----------------
    logic [SIDE_S-1:0]    sside_in, sside_out;
    logic                 sqrt_valid;
    logic [RW-1:0]        root_s, magdx_s, magdy_s, r_s;
    logic                 hit_s, sdx_s, sdy_s;

    assign sside_in = {hit7_reg, sdx7_reg, sdy7_reg, magdx7_reg, magdy7_reg, r7_reg};
    assign {hit_s, sdx_s, sdy_s, magdx_s, magdy_s, r_s} = sside_out;

    csp_isqrt_pipe #(
        .N      (RW),
        .SIDE_W (SIDE_S)
    ) u_isqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .ce        (ce),
        .in_valid  (v7_reg),
        .rad_in    (rad7_reg),
        .side_in   (sside_in),
        .out_valid (sqrt_valid),
        .root_out  (root_s),
        .side_out  (sside_out)
    );

    // ---------------- stage 8: floored distance and overlap ----------------
    logic [RW-1:0]        dist_n;
    logic signed [W-1:0]  ovl_n;
    logic [W-1:0]         absovl;
    logic                 v8_reg;
    logic [RW-1:0]        dist8_reg, magovl8_reg, magdx8_reg, magdy8_reg;
    logic                 negx8_reg, negy8_reg, hit8_reg;

    assign dist_n = (root_s < DIST_MIN) ? DIST_MIN : root_s;
    assign ovl_n  = $signed({1'b0, r_s}) - $signed({1'b0, dist_n});
    assign absovl = ovl_n[W-1] ? $unsigned(-ovl_n) : $unsigned(ovl_n);

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            dist8_reg   <= dist_n;
            magovl8_reg <= absovl[RW-1:0];
            magdx8_reg  <= magdx_s;
            magdy8_reg  <= magdy_s;
            negx8_reg   <= sdx_s ^ ovl_n[W-1];
            negy8_reg   <= sdy_s ^ ovl_n[W-1];
            hit8_reg    <= hit_s;
        end
    end

    // ---------------- stage 9: d * overlap ----------------
    logic [2*RW-1:0]      numx_p, numy_p;
    logic                 v9_reg;
    logic [2*RW-1:0]      num9x_reg, num9y_reg;
    logic [RW-1:0]        dist9_reg;
    logic                 negx9_reg, negy9_reg, hit9_reg;

    assign numx_p = magdx8_reg * magovl8_reg;
    assign numy_p = magdy8_reg * magovl8_reg;

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            num9x_reg <= numx_p;
            num9y_reg <= numy_p;
            dist9_reg <= dist8_reg;
            negx9_reg <= negx8_reg;
            negy9_reg <= negy8_reg;
            hit9_reg  <= hit8_reg;
        end
    end

    // ---------------- push dividers: d * overlap / dist ----------------
    // |d| <= dist, so each quotient is at most |overlap| and never saturates.
    logic                 pdx_valid, pdy_valid;
    logic [RW-1:0]        qx, qy;
    logic [1:0]           xside_out;
    logic [0:0]           yside_out;

    csp_div_pipe #(
        .D_W    (RW),
        .STEPS  (RW),
        .SIDE_W (2)
    ) u_pdiv_x (
        .clk       (clk),
        .rst_n     (rst_n),
        .ce        (ce),
        .in_valid  (v9_reg),
        .rem_in    (num9x_reg[2*RW-1:RW]),
        .qn_in     (num9x_reg[RW-1:0]),
        .div_in    (dist9_reg),
        .side_in   ({hit9_reg, negx9_reg}),
        .out_valid (pdx_valid),
        .q_out     (qx),
        .side_out  (xside_out)
    );

    csp_div_pipe #(
        .D_W    (RW),
        .STEPS  (RW),
        .SIDE_W (1)
    ) u_pdiv_y (
        .clk       (clk),
        .rst_n     (rst_n),
        .ce        (ce),
        .in_valid  (v9_reg),
        .rem_in    (num9y_reg[2*RW-1:RW]),
        .qn_in     (num9y_reg[RW-1:0]),
        .div_in    (dist9_reg),
        .side_in   (negy9_reg),
        .out_valid (pdy_valid),
        .q_out     (qy),
        .side_out  (yside_out)
    );

    // ---------------- output register ----------------
    logic signed [W-1:0]  pushx_n, pushy_n;
    logic signed [W-1:0]  push_x_reg, push_y_reg;
    logic                 hit_reg;

    assign pushx_n = xside_out[0] ? -$signed(W'(qx)) : $signed(W'(qx));
    assign pushy_n = yside_out[0] ? -$signed(W'(qy)) : $signed(W'(qy));

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            hit_reg    <= xside_out[1];
            push_x_reg <= xside_out[1] ? pushx_n : '0;
            push_y_reg <= xside_out[1] ? pushy_n : '0;
        end
    end

    // Valid bits of stages 1 to 9 and the output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg       <= 1'b0;
            v2_reg       <= 1'b0;
            v3_reg       <= 1'b0;
            v4_reg       <= 1'b0;
            v5_reg       <= 1'b0;
            v6_reg       <= 1'b0;
            v7_reg       <= 1'b0;
            v8_reg       <= 1'b0;
            v9_reg       <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else if (ce)
        begin
            v1_reg       <= s_tvalid;
            v2_reg       <= v1_reg;
            v3_reg       <= v2_reg;
            v4_reg       <= tdiv_valid;
            v5_reg       <= v4_reg;
            v6_reg       <= v5_reg;
            v7_reg       <= v6_reg;
            v8_reg       <= sqrt_valid;
            v9_reg       <= v8_reg;
            m_tvalid_reg <= pdx_valid && pdy_valid;
        end
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = OUT_TW'({push_y_reg, push_x_reg});
    assign m_tuser[0] = hit_reg;

`ifndef SYNTHESIS
    // A miss always reports a zero push vector
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |-> m_tdata == '0)
        else $error("push vector not zero on a miss");

    // The floored distance never drops below the minimum
    a_dist_floor: assert property (@(posedge clk) disable iff (!rst_n)
        v8_reg |-> dist8_reg >= DIST_MIN)
        else $error("distance below floor");

    // Push divider precondition: quotient fits, high part below the divisor
    a_pdiv_range: assert property (@(posedge clk) disable iff (!rst_n)
        v9_reg && hit9_reg |-> num9x_reg[2*RW-1:RW] < dist9_reg
                            && num9y_reg[2*RW-1:RW] < dist9_reg)
        else $error("push quotient out of range");

    // An empty output register never blocks the input
    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");
`endif

endmodule

// File: test/circle_segment_pushout_tb.sv
// Testbench for circle_segment_pushout: directed and random circle/segment tests.
// Depends on csp_pkg and the circle_segment_pushout RTL; self-checking, no files read.
module circle_segment_pushout_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int    PIPE_LATENCY = 42 + 2 * (csp_pkg::COORD_WIDTH - 1);
    localparam int    CYCLE_LIMIT  = 400000;
    localparam int    RANDOM_ITEMS = 1830;
    // degenerate segment floor (raw units squared) and minimum distance (raw)
    localparam int    LEN2_FLOOR   = 43;
    localparam int    DIST_FLOOR   = 66;
    localparam logic signed [31:0] ONE = 32'sh0001_0000;

    typedef struct packed {
        logic signed [31:0] cx;
        logic signed [31:0] cy;
        logic        [30:0] radius;
        logic signed [31:0] sx;
        logic signed [31:0] sy;
        logic signed [31:0] ex;
        logic signed [31:0] ey;
    } seg_test_t;

    typedef struct packed {
        logic               hit;
        logic signed [31:0] push_x;
        logic signed [31:0] push_y;
    } pushout_t;

    typedef struct {
        seg_test_t tst;
        bit        typed;
        pushout_t  known;
    } stim_row_t;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [223:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [63:0]  m_tdata;
    logic [0:0]   m_tuser;

    pushout_t  pending_q[$];
    stim_row_t stim_rows[$];
    int        errors;
    int        cycles;
    int        results_seen;
    int        hits_seen;
    int        ready_pct;

    circle_segment_pushout dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),   // cx, cy, radius, sx, sy, ex, ey (lowest first)
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),   // push_x, push_y (lowest first)
        .m_tuser  (m_tuser)    // hit
    );

    // clock, 8 ns period
    initial clk = 1'b0;
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic logic signed [127:0] abs128(input logic signed [127:0] v);
        return v < 0 ? -v : v;
    endfunction

    // saturate a magnitude with sign to the signed 32-bit range
    function automatic logic signed [31:0] clamp_push(input logic signed [127:0] mag,
                                                      input bit neg);
        if (!neg)
            return (mag > 128'sh7FFF_FFFF) ? 32'sh7FFF_FFFF : mag[31:0];
        if (mag > 128'sh8000_0000)
            return 32'sh8000_0000;
        return -mag[31:0];
    endfunction

    // expected push-out for one circle/segment test
    function automatic pushout_t pushout_calc(input seg_test_t it);
        logic signed [127:0] ax, ay, bx, by, px, py, abx, aby, len2, dot, t;
        logic signed [127:0] mx, my, clx, cly, dx, dy, dist2, r, r2, dist_v, c, ovl;
        pushout_t res;
        res = '0;
        ax = it.sx;  ay = it.sy;  bx = it.ex;  by = it.ey;
        px = it.cx;  py = it.cy;
        r = {97'd0, it.radius};
        abx = bx - ax;
        aby = by - ay;
        len2 = abx * abx + aby * aby;
        if (len2 < LEN2_FLOOR)
            return res;
        // projection parameter with 32 fraction bits, clamped to [0,1]
        dot = (px - ax) * abx + (py - ay) * aby;
        if (dot <= 0)
            t = 0;
        else if (dot >= len2)
            t = 128'sd1 <<< csp_pkg::T_BITS;
        else
            t = (dot <<< csp_pkg::T_BITS) / len2;
        mx = (t * abs128(abx)) >>> csp_pkg::T_BITS;
        my = (t * abs128(aby)) >>> csp_pkg::T_BITS;
        clx = abx < 0 ? ax - mx : ax + mx;
        cly = aby < 0 ? ay - my : ay + my;
        dx = px - clx;
        dy = py - cly;
        dist2 = dx * dx + dy * dy;
        r2 = r * r;
        if (dist2 >= r2)
            return res;
        // integer square root, then the distance floor
        dist_v = 0;
        for (int b = 31; b >= 0; b--)
        begin
            c = dist_v | (128'sd1 <<< b);
            if (c * c <= dist2)
                dist_v = c;
        end
        if (dist_v < DIST_FLOOR)
            dist_v = DIST_FLOOR;
        ovl = r - dist_v;
        res.hit = 1'b1;
        res.push_x = clamp_push(abs128(dx) * abs128(ovl) / dist_v, (dx < 0) != (ovl < 0));
        res.push_y = clamp_push(abs128(dy) * abs128(ovl) / dist_v, (dy < 0) != (ovl < 0));
        return res;
    endfunction

    // drive one test and wait for its transaction; record the expected result
    task automatic send_test(input seg_test_t it, input bit typed, input pushout_t known);
        s_tdata  <= {1'b0, it.ey, it.ex, it.sy, it.sx, it.radius, it.cy, it.cx};
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        pending_q.push_back(typed ? known : pushout_calc(it));
    endtask

    function automatic logic signed [31:0] span_rand(input int sh);
        return $signed(($urandom & ((32'd1 << sh) - 1))) - $signed(32'd1 << (sh - 1));
    endfunction

    // random test: mostly geometry near the segment, some raw noise
    function automatic seg_test_t random_test();
        seg_test_t it;
        logic signed [31:0] base_x, base_y;
        int sh;
        if ($urandom_range(0, 3) == 0)
        begin
            it.cx = $urandom;  it.cy = $urandom;  it.radius = 31'($urandom);
            it.sx = $urandom;  it.sy = $urandom;  it.ex = $urandom;  it.ey = $urandom;
            return it;
        end
        sh = $urandom_range(2, 28);
        base_x = span_rand(30);
        base_y = span_rand(30);
        it.sx = base_x + span_rand(sh);
        it.sy = base_y + span_rand(sh);
        it.ex = base_x + span_rand(sh);
        it.ey = base_y + span_rand(sh);
        it.cx = base_x + span_rand(sh);
        it.cy = base_y + span_rand(sh);
        it.radius = 31'($urandom & ((32'd1 << sh) - 1));
        return it;
    endfunction

    function automatic seg_test_t mk(input logic signed [31:0] cx, cy,
                                     input logic [30:0] radius,
                                     input logic signed [31:0] sx, sy, ex, ey);
        seg_test_t it;
        it.cx = cx;  it.cy = cy;  it.radius = radius;
        it.sx = sx;  it.sy = sy;  it.ex = ex;  it.ey = ey;
        return it;
    endfunction

    // watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout at %0t, %0d results outstanding", $realtime, pending_q.size());
            $display("TB_ERROR");
            $finish;
        end
    end

    // receiver: result check and stall pattern
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (pending_q.size() == 0)
                begin
                    $display("%0t: unexpected result hit=%0b push=(%0d,%0d)", $realtime,
                             m_tuser[0], $signed(m_tdata[31:0]), $signed(m_tdata[63:32]));
                    errors++;
                end
                else
                begin
                    pushout_t want;
                    want = pending_q.pop_front();
                    results_seen++;
                    if (want.hit)
                        hits_seen++;
                    if (m_tuser[0] !== want.hit)
                    begin
                        $display("%0t: hit expected %0b actual %0b", $realtime,
                                 want.hit, m_tuser[0]);
                        errors++;
                    end
                    if (m_tdata[31:0] !== want.push_x)
                    begin
                        $display("%0t: push_x expected %0d actual %0d", $realtime,
                                 want.push_x, $signed(m_tdata[31:0]));
                        errors++;
                    end
                    if (m_tdata[63:32] !== want.push_y)
                    begin
                        $display("%0t: push_y expected %0d actual %0d", $realtime,
                                 want.push_y, $signed(m_tdata[63:32]));
                        errors++;
                    end
                end
            end
            // stall mix changes at regular intervals; every fourth interval has no stalls
            if (cycles % 300 == 0)
                ready_pct <= (cycles / 300) % 4 == 0 ? 100 : $urandom_range(20, 90);
            m_tready <= ($urandom_range(1, 100) <= ready_pct);
        end
    end

    initial
    begin
        int burst_left;
        int gap;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        errors = 0;
        cycles = 0;
        results_seen = 0;
        hits_seen = 0;
        ready_pct = 100;

        // directed rows; typed results only where they are obvious
        stim_rows.push_back('{mk(0, 0, ONE, 0, 0, 0, 0), 1'b1, '0});          // zero length
        stim_rows.push_back('{mk(0, 0, ONE, 0, 0, 6, 0), 1'b1, '0});          // below len floor
        stim_rows.push_back('{mk(5 * ONE, 0, 0, 0, 0, 10 * ONE, 0), 1'b1, '0}); // zero radius
        stim_rows.push_back('{mk(5 * ONE, ONE, ONE, 0, 0, 10 * ONE, 0), 1'b1, '0}); // touching
        stim_rows.push_back('{mk(5 * ONE, 0, ONE, 0, 0, 10 * ONE, 0), 1'b1,
                              '{1'b1, 32'sd0, 32'sd0}});                      // center on line
        stim_rows.push_back('{mk(5 * ONE, ONE / 2, ONE, 0, 0, 10 * ONE, 0), 1'b1,
                              '{1'b1, 32'sd0, 32'sh8000}});                   // half overlap
        stim_rows.push_back('{mk(-ONE, 0, 2 * ONE, 0, 0, 10 * ONE, 0), 1'b0, '0}); // t low
        stim_rows.push_back('{mk(11 * ONE, ONE / 2, 2 * ONE, 0, 0, 10 * ONE, 0), 1'b0, '0});
        stim_rows.push_back('{mk(5 * ONE, 5, 10, 0, 0, 10 * ONE, 0), 1'b0, '0}); // inward push
        stim_rows.push_back('{mk(5 * ONE, -5, 10, 0, 0, 10 * ONE, 0), 1'b0, '0});
        stim_rows.push_back('{mk(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 31'h7FFF_FFFF,
                                 32'sh8000_0000, 32'sh8000_0000,
                                 32'sh7FFF_FFFF, 32'sh7FFF_FFFF), 1'b0, '0});
        stim_rows.push_back('{mk(32'sh8000_0000, 32'sh8000_0000, 0,
                                 32'sh8000_0000, 32'sh8000_0000,
                                 32'sh8000_0000, 32'sh8000_0000), 1'b1, '0});
        stim_rows.push_back('{mk(0, 0, 31'h7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF,
                                 32'sh7FFF_FFFF, 32'sh8000_0000), 1'b0, '0});
        stim_rows.push_back('{mk(0, 32'sh7FFF_FFFF, 31'h7FFF_FFFF, 32'sh8000_0000, 0,
                                 32'sh7FFF_FFFF, 0), 1'b0, '0});
        stim_rows.push_back('{mk(-ONE / 2, 3 * ONE, ONE, 0, 10 * ONE, 0, -10 * ONE),
                              1'b0, '0});                                     // reversed
        stim_rows.push_back('{mk(ONE, 0, 2 * ONE, 0, 0, 3 * ONE, 4 * ONE), 1'b0, '0});
        stim_rows.push_back('{mk(-7 * ONE, 2 * ONE, 3 * ONE, -5 * ONE, 5 * ONE,
                                 -9 * ONE, -4 * ONE), 1'b0, '0});
        stim_rows.push_back('{mk(32'sh7000_0000, 0, ONE, 32'sh8000_0000, 0,
                                 32'sh8001_0000, 0), 1'b1, '0});              // far miss

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (stim_rows[i])
            send_test(stim_rows[i].tst, stim_rows[i].typed, stim_rows[i].known);
        s_tvalid <= 1'b0;

        // hold off until the pipeline has drained
        while (pending_q.size() != 0)
            @(posedge clk);

        // random part in bursts
        burst_left = 0;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 40);
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                if (gap != 0)
                begin
                    s_tvalid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
            send_test(random_test(), 1'b0, '0);
            burst_left--;
        end
        s_tvalid <= 1'b0;

        while (pending_q.size() != 0)
            @(posedge clk);
        repeat (PIPE_LATENCY + 20) @(posedge clk);

        $display("checked %0d push-out results, %0d of them hits, under random stalls",
                 results_seen, hits_seen);
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
